/* src/eas_pkg.sv */
// Shared types and constants for the encoder angle smoother.
package eas_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int OFFSET_CHANNELS  = 3;

    localparam int CH_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int OFF_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int ANGLE_W   = 19;
    localparam int OUT_W     = 20;
    localparam int FILT_W    = 23;
    localparam int FRAC_BITS = 4;

    localparam int RAW_W         = 14;
    localparam int RAW_MAX       = 16383;
    localparam int SCALE_MUL     = 460800;
    localparam int HALF_DIV      = 8191;
    localparam int ANGLE_BIAS    = 230400;
    localparam int ONE_DEG_STATE = 20480;
    localparam int STEP_SHIFT    = 7;

    // floor(x/5) == (x * DIV5_MUL) >> DIV5_SHIFT for any x below 2**32
    localparam logic [31:0] DIV5_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOBAL_CH0 = 3'd0,
        CFG_GLOBAL_CH1 = 3'd1,
        CFG_GLOBAL_CH2 = 3'd2,
        CFG_LIVE_CH0   = 3'd3,
        CFG_LIVE_CH1   = 3'd4,
        CFG_LIVE_CH2   = 3'd5
    } t_cfg_idx;

    typedef logic signed [FILT_W-1:0] t_filt;
    typedef logic signed [OFF_W-1:0]  t_off;

endpackage

/* src/encoder_angle_smoother.sv */
// Encoder angle smoother: raw sensor bytes to a per-channel filtered angle with offsets.
// An accepted request's result is valid once it has passed the stage 1 and output registers.
// Throughput: one request per cycle unless the output stalls; the angle scaling (constant divide by 16383) sits
// in the first stage, the per-channel filter update (divide by 5) in the second.
// Requests with a channel at or above NUM_CHANNELS give no result.
// Reset (sync, active low) empties both stages, zeroes all offsets and loads each
// channel's filter state with (channel + 1) degrees.
module encoder_angle_smoother #(
    parameter int NUM_CHANNELS = eas_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [eas_pkg::CH_W-1:0]            i_channel,
    input  logic [eas_pkg::BYTE_W-1:0]          i_high_byte,
    input  logic [eas_pkg::BYTE_W-1:0]          i_low_byte,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [eas_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [eas_pkg::OFF_W-1:0]           i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [eas_pkg::CH_W-1:0]            o_channel_out,
    output logic signed [eas_pkg::ANGLE_W-1:0]  o_smoothed_angle,
    output logic signed [eas_pkg::OUT_W-1:0]    o_angle_less_global,
    output logic signed [eas_pkg::OUT_W-1:0]    o_angle_less_both,
    output logic signed [eas_pkg::OUT_W-1:0]    o_angle_delta
);
    import eas_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // pipeline control
    logic r_s1_valid;
    logic r_out_valid;
    logic w_out_load;
    logic w_s1_adv;
    logic w_in_acc;
    logic w_ch_ok;

    // state and configuration
    t_filt r_filt [NUM_CHANNELS];
    t_off  r_glob [OFFSET_CHANNELS];
    t_off  r_live [OFFSET_CHANNELS];

    // stage 1 registers
    logic [CH_W-1:0]           r_s1_ch;
    logic signed [ANGLE_W-1:0] r_s1_angle;

    // stage 1 logic
    logic [RAW_W-1:0] w_raw;
    logic [RAW_W-1:0] w_inv;
    logic [32:0]      w_num;
    logic [18:0]      w_hi;
    logic [19:0]      w_sum1;
    logic [14:0]      w_sum2;
    logic [18:0]      w_quo;
    logic [19:0]      w_angle_ext;

    // stage 2 logic
    logic [IDX_W-1:0]       w_idx;
    t_filt                  w_filt_old;
    t_filt                  w_target;
    logic signed [FILT_W:0] w_diff;
    logic                   w_neg;
    logic [FILT_W-1:0]      w_mag;
    logic [54:0]            w_prod;
    logic [20:0]            w_q5;
    t_filt                  w_step;
    t_filt                  w_filt_new;
    logic signed [FILT_W:0] w_rnd_new;
    logic signed [FILT_W:0] w_rnd_old;
    logic signed [20:0]     w_sm;
    logic signed [20:0]     w_prv;
    t_off                   w_g;
    t_off                   w_l;
    logic signed [20:0]     w_g_units;
    logic signed [20:0]     w_l_units;
    logic signed [20:0]     w_less_g;
    logic signed [20:0]     w_less_both;
    logic signed [20:0]     w_delta;

    // output registers
    logic [CH_W-1:0]           r_out_ch;
    logic signed [ANGLE_W-1:0] r_out_sm;
    logic signed [OUT_W-1:0]   r_out_less_g;
    logic signed [OUT_W-1:0]   r_out_less_both;
    logic signed [OUT_W-1:0]   r_out_delta;

    assign w_out_load  = !r_out_valid || i_ready;
    assign w_s1_adv    = r_s1_valid && w_out_load;
    assign o_ready     = !r_s1_valid || w_out_load;
    assign w_in_acc    = i_valid && o_ready;
    assign w_ch_ok     = (32'(i_channel) < NUM_CHANNELS);
    assign o_cfg_ready = 1'b1;

    // Stage 1: angle = (inv*460800 + 8191) / 16383 - 230400.
    // Divide by 2**14-1 by folding the high part back into the low part twice.
    always_comb begin
        w_raw       = {i_high_byte, i_low_byte[5:0]};
        w_inv       = RAW_W'(RAW_MAX) - w_raw;
        w_num       = 33'(w_inv) * 33'(SCALE_MUL) + 33'(HALF_DIV);
        w_hi        = w_num[32:14];
        w_sum1      = 20'(w_hi) + 20'(w_num[13:0]);
        w_sum2      = 15'(w_sum1[19:14]) + 15'(w_sum1[13:0]);
        w_quo       = w_hi + 19'(w_sum1[19:14]) + 19'(w_sum2 >= 15'(RAW_MAX));
        w_angle_ext = 20'(w_quo) - 20'(ANGLE_BIAS);
    end

    // Stage 2: filtered += (16*angle - filtered)/5, truncating toward zero.
    always_comb begin
        w_idx      = IDX_W'(r_s1_ch);
        w_filt_old = r_filt[w_idx];
        w_target   = {r_s1_angle, {FRAC_BITS{1'b0}}};
        w_diff     = {w_target[FILT_W-1], w_target} - {w_filt_old[FILT_W-1], w_filt_old};
        w_neg      = w_diff[FILT_W];
        w_mag      = w_neg ? FILT_W'(-w_diff) : FILT_W'(w_diff);
        w_prod     = 55'(w_mag) * 55'(DIV5_MUL);
        w_q5       = w_prod[54:DIV5_SHIFT];
        w_step     = w_neg ? -t_filt'(w_q5) : t_filt'(w_q5);
        w_filt_new = w_filt_old + w_step;

        // round half up: floor((v + 8) / 16)
        w_rnd_new  = {w_filt_new[FILT_W-1], w_filt_new} + 24'sd8;
        w_rnd_old  = {w_filt_old[FILT_W-1], w_filt_old} + 24'sd8;
        w_sm       = {w_rnd_new[FILT_W], w_rnd_new[FILT_W:FRAC_BITS]};
        w_prv      = {w_rnd_old[FILT_W], w_rnd_old[FILT_W:FRAC_BITS]};

        // channels without offset registers use zero offsets
        if (r_s1_ch < CH_W'(OFFSET_CHANNELS)) begin
            w_g = r_glob[r_s1_ch];
            w_l = r_live[r_s1_ch];
        end else begin
            w_g = '0;
            w_l = '0;
        end
        w_g_units   = {{(21 - OFF_W - STEP_SHIFT){w_g[OFF_W-1]}}, w_g, {STEP_SHIFT{1'b0}}};
        w_l_units   = {{(21 - OFF_W - STEP_SHIFT){w_l[OFF_W-1]}}, w_l, {STEP_SHIFT{1'b0}}};
        w_less_g    = w_sm - w_g_units;
        w_less_both = w_less_g - w_l_units;
        w_delta     = w_sm - w_prv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_filt[c] <= t_filt'((c + 1) * ONE_DEG_STATE);
            end
            for (int c = 0; c < OFFSET_CHANNELS; c++) begin
                r_glob[c] <= '0;
                r_live[c] <= '0;
            end
        end else begin
            // drop requests for channels that do not exist
            if (o_ready) begin
                r_s1_valid <= w_in_acc && w_ch_ok;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_s1_adv) begin
                r_filt[w_idx] <= w_filt_new;
            end
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GLOBAL_CH0: r_glob[0] <= t_off'(i_cfg_data);
                    CFG_GLOBAL_CH1: r_glob[1] <= t_off'(i_cfg_data);
                    CFG_GLOBAL_CH2: r_glob[2] <= t_off'(i_cfg_data);
                    CFG_LIVE_CH0:   r_live[0] <= t_off'(i_cfg_data);
                    CFG_LIVE_CH1:   r_live[1] <= t_off'(i_cfg_data);
                    CFG_LIVE_CH2:   r_live[2] <= t_off'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_ch    <= i_channel;
            r_s1_angle <= w_angle_ext[ANGLE_W-1:0];
        end
        if (w_s1_adv) begin
            r_out_ch        <= r_s1_ch;
            r_out_sm        <= w_sm[ANGLE_W-1:0];
            r_out_less_g    <= w_less_g[OUT_W-1:0];
            r_out_less_both <= w_less_both[OUT_W-1:0];
            r_out_delta     <= w_delta[OUT_W-1:0];
        end
    end

    assign o_valid             = r_out_valid;
    assign o_channel_out       = r_out_ch;
    assign o_smoothed_angle    = r_out_sm;
    assign o_angle_less_global = r_out_less_g;
    assign o_angle_less_both   = r_out_less_both;
    assign o_angle_delta       = r_out_delta;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the encoder angle smoother: directed, stall and random tests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import eas_pkg::*;

    localparam int NUM_CH         = NUM_CHANNELS_DEF;
    localparam int MAX_GAP        = 18;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_READINGS = 250;
    localparam int MAX_REPORTED   = 10;

    localparam int RAW_TOP     = 16383;
    localparam int FULL_SCALE  = 460800;
    localparam int HALF_SPAN   = 230400;
    localparam int DEG_STATE   = 20480;
    localparam int FRAC_SCALE  = 16;
    localparam int STEP_UNITS  = 128;
    localparam int FILTER_DIV  = 5;

    // register indexes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [CH_W-1:0]    channel;
        logic [ANGLE_W-1:0] smoothed;
        logic [OUT_W-1:0]   less_global;
        logic [OUT_W-1:0]   less_both;
        logic [OUT_W-1:0]   delta;
    } t_angle_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [CH_W-1:0]       i_channel;
    logic [BYTE_W-1:0]     i_high_byte;
    logic [BYTE_W-1:0]     i_low_byte;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [OFF_W-1:0]      i_cfg_data;
    logic                  o_valid;
    logic                  i_ready;
    logic [CH_W-1:0]       o_channel_out;
    logic signed [ANGLE_W-1:0] o_smoothed_angle;
    logic signed [OUT_W-1:0]   o_angle_less_global;
    logic signed [OUT_W-1:0]   o_angle_less_both;
    logic signed [OUT_W-1:0]   o_angle_delta;

    encoder_angle_smoother #(
        .NUM_CHANNELS(NUM_CH)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_channel           (i_channel),
        .i_high_byte         (i_high_byte),
        .i_low_byte          (i_low_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_channel_out       (o_channel_out),
        .o_smoothed_angle    (o_smoothed_angle),
        .o_angle_less_global (o_angle_less_global),
        .o_angle_less_both   (o_angle_less_both),
        .o_angle_delta       (o_angle_delta)
    );

    // shadow of the block's filter state and offsets
    t_filt filt_state [NUM_CH];
    t_filt prev_state [NUM_CH];
    t_off  glob_offset [OFFSET_CHANNELS];
    t_off  live_offset [OFFSET_CHANNELS];

    t_angle_report awaited_reports [$];

    int  error_count    = 0;
    int  readings_sent  = 0;
    int  ignored_sent   = 0;
    int  reports_seen   = 0;
    int  offset_writes  = 0;
    int  quiet_cycles   = 0;
    bit  tx_no_gaps     = 1'b0;
    bit  rx_no_gaps     = 1'b0;
    bit  rx_hold_pending = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_shadow();
        for (int c = 0; c < NUM_CH; c++) begin
            filt_state[c] = t_filt'((c + 1) * DEG_STATE);
            prev_state[c] = filt_state[c];
        end
        for (int c = 0; c < OFFSET_CHANNELS; c++) begin
            glob_offset[c] = '0;
            live_offset[c] = '0;
        end
    endfunction

    // Advance the channel's filter and queue the report it should produce.
    function automatic void smooth_reading(logic [CH_W-1:0] ch, logic [BYTE_W-1:0] hb,
                                           logic [BYTE_W-1:0] lb);
        logic [RAW_W-1:0]  raw;
        longint unsigned   inv;
        int                angle, diff, sm, prv, g, l;
        t_angle_report     rpt;
        if (ch >= NUM_CH)
            return;
        raw   = {hb, lb[5:0]};
        inv   = RAW_TOP - raw;
        angle = int'((inv * FULL_SCALE + RAW_TOP / 2) / RAW_TOP) - HALF_SPAN;
        prev_state[ch] = filt_state[ch];
        diff  = angle * FRAC_SCALE - int'(filt_state[ch]);
        // signed divide truncates toward zero
        filt_state[ch] = t_filt'(int'(filt_state[ch]) + diff / FILTER_DIV);
        g = 0;
        l = 0;
        if (ch < OFFSET_CHANNELS) begin
            g = int'(glob_offset[ch]);
            l = int'(live_offset[ch]);
        end
        // round halves up: floor((v + 8) / 16)
        sm = (int'(filt_state[ch]) + FRAC_SCALE / 2) >>> 4;
        prv = (int'(prev_state[ch]) + FRAC_SCALE / 2) >>> 4;
        rpt.channel     = ch;
        rpt.smoothed    = ANGLE_W'(sm);
        rpt.less_global = OUT_W'(sm - g * STEP_UNITS);
        rpt.less_both   = OUT_W'(sm - g * STEP_UNITS - l * STEP_UNITS);
        rpt.delta       = OUT_W'(sm - prv);
        awaited_reports.push_back(rpt);
    endfunction

    // Offer one reading and hold it until the block takes it.
    task automatic send_reading(logic [CH_W-1:0] ch, logic [BYTE_W-1:0] hb,
                                logic [BYTE_W-1:0] lb);
        int unsigned gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_channel   <= ch;
        i_high_byte <= hb;
        i_low_byte  <= lb;
        do @(posedge i_clk); while (!o_ready);
        smooth_reading(ch, hb, lb);
        if (ch < NUM_CH)
            readings_sent++;
        else
            ignored_sent++;
    endtask

    task automatic send_raw(logic [CH_W-1:0] ch, int raw);
        logic [1:0] junk;
        junk = 2'($urandom_range(0, 3));
        send_reading(ch, raw[13:6], {junk, raw[5:0]});
    endtask

    task automatic write_offset(logic [CFG_IDX_W-1:0] idx, t_off val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < CFG_LIVE_CH0)
            glob_offset[2'(idx)] = val;
        else if (idx <= CFG_LIVE_CH2)
            live_offset[2'(idx - CFG_LIVE_CH0)] = val;
        offset_writes++;
    endtask

    task automatic apply_offsets(t_off g0, t_off g1, t_off g2, t_off l0, t_off l1, t_off l2,
                                 bit poke_spare);
        t_off vals [6];
        vals = '{g0, g1, g2, l0, l1, l2};
        for (int r = 0; r < 6; r++)
            write_offset(CFG_IDX_W'(int'(CFG_GLOBAL_CH0) + r), vals[r]);
        if (poke_spare) begin
            write_offset(CFG_SPARE_LO, t_off'($urandom_range(0, 255)));
            write_offset(CFG_SPARE_HI, t_off'($urandom_range(0, 255)));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every queued report has come back.
    task automatic drain_reports();
        i_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_off rand_offset();
        return t_off'($urandom_range(0, 255));
    endfunction

    task automatic test_reading_extremes();
        for (int c = 0; c < NUM_CH; c++) begin
            send_reading(CH_W'(c), 8'h00, 8'h00);
            send_reading(CH_W'(c), 8'hFF, 8'h3F);
            // top two bits of the low byte must be dropped
            send_reading(CH_W'(c), 8'h00, 8'hFF);
            send_reading(CH_W'(c), 8'h80, 8'hC0);
        end
    endtask

    task automatic test_ignored_channel();
        send_reading(CH_W'(NUM_CH), 8'hFF, 8'hFF);
        send_reading(CH_W'(0), 8'h40, 8'h15);
        send_reading(CH_W'(NUM_CH), 8'h00, 8'h00);
        send_reading(CH_W'(1), 8'hC3, 8'h2A);
    endtask

    task automatic test_offset_writes();
        drain_reports();
        apply_offsets(-128, 127, 1, 127, -128, -1, 1'b1);
        for (int c = 0; c < NUM_CH; c++)
            send_raw(CH_W'(c), $urandom_range(0, RAW_TOP));
    endtask

    task automatic test_output_stall();
        drain_reports();
        rx_no_gaps      = 1'b0;
        tx_no_gaps      = 1'b1;
        rx_hold_pending = 1'b1;
        for (int k = 0; k < 40; k++)
            send_raw(CH_W'($urandom_range(0, NUM_CH - 1)), $urandom_range(0, RAW_TOP));
        tx_no_gaps = 1'b0;
        drain_reports();
    endtask

    // Runs of near-steady readings per channel, mixed with noise, over several offset setups.
    task automatic test_random_tracks();
        int phase_count, target, len, raw, ch;
        for (int phase = 0; phase < 6; phase++) begin
            drain_reports();
            case (phase)
                0: apply_offsets(127, 127, 127, 127, 127, 127, 1'b0);
                1: apply_offsets(-128, -128, -128, -128, -128, -128, 1'b1);
                2: apply_offsets(0, 0, 0, 0, 0, 0, 1'b1);
                default: apply_offsets(rand_offset(), rand_offset(), rand_offset(),
                                       rand_offset(), rand_offset(), rand_offset(), 1'b1);
            endcase
            phase_count = 0;
            while (phase_count < PHASE_READINGS) begin
                tx_no_gaps = ($urandom_range(0, 4) == 0);
                rx_no_gaps = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) < 2) begin
                    ch = $urandom_range(0, 3);
                    send_reading(CH_W'(ch), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                    if (ch < NUM_CH)
                        phase_count++;
                end else begin
                    ch = $urandom_range(0, NUM_CH - 1);
                    case ($urandom_range(0, 3))
                        0: target = 0;
                        1: target = RAW_TOP;
                        default: target = $urandom_range(0, RAW_TOP);
                    endcase
                    len = $urandom_range(1, 30);
                    for (int k = 0; k < len; k++) begin
                        raw = target + int'($urandom_range(0, 16)) - 8;
                        if (raw < 0)
                            raw = 0;
                        if (raw > RAW_TOP)
                            raw = RAW_TOP;
                        send_raw(CH_W'(ch), raw);
                    end
                    phase_count += len;
                end
            end
        end
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;
    endtask

    // Result side: random stall before each report, one long hold on request.
    initial begin
        int unsigned wait_n;
        i_ready <= 1'b0;
        forever begin
            if (rx_hold_pending) begin
                rx_hold_pending = 1'b0;
                wait_n = RX_HOLD_CYCLES;
            end else begin
                wait_n = rx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (wait_n > 0) begin
                i_ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    task automatic flag_field(string label, logic [31:0] want, logic [31:0] got);
        if (error_count < MAX_REPORTED)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, label, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_angle_report want;
        if (i_rst_n && o_valid && i_ready) begin
            reports_seen++;
            if (awaited_reports.size() == 0) begin
                flag_field("unexpected report, channel", '0, 32'(o_channel_out));
            end else begin
                want = awaited_reports.pop_front();
                if (o_channel_out !== want.channel)
                    flag_field("channel_out", 32'(want.channel), 32'(o_channel_out));
                if (o_smoothed_angle !== want.smoothed)
                    flag_field("smoothed_angle", 32'(want.smoothed),
                               32'($unsigned(o_smoothed_angle)));
                if (o_angle_less_global !== want.less_global)
                    flag_field("angle_less_global", 32'(want.less_global),
                               32'($unsigned(o_angle_less_global)));
                if (o_angle_less_both !== want.less_both)
                    flag_field("angle_less_both", 32'(want.less_both),
                               32'($unsigned(o_angle_less_both)));
                if (o_angle_delta !== want.delta)
                    flag_field("angle_delta", 32'(want.delta),
                               32'($unsigned(o_angle_delta)));
            end
        end
    end

    // Watchdog: count cycles where no request moves on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d reports outstanding",
                     quiet_cycles, awaited_reports.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_channel   <= '0;
        i_high_byte <= '0;
        i_low_byte  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_offsets(127, -128, 0, -128, 127, 0, 1'b0);
        test_reading_extremes();
        test_ignored_channel();
        test_offset_writes();
        test_output_stall();
        test_random_tracks();
        drain_reports();

        if (awaited_reports.size() != 0) begin
            $display("%0d reports never arrived", awaited_reports.size());
            error_count += awaited_reports.size();
        end
        $display("Covered %0d readings on live channels and %0d on the unused one; %0d reports",
                 readings_sent, ignored_sent, reports_seen);
        $display("checked across %0d offset writes, a long output stall and gap-free bursts.",
                 offset_writes);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
